// ===== sv/dqe_pkg.sv =====
// ----------------------------------------------------------------------------
// dqe_pkg
// Shared types and constants of the bounded double-ended queue.
// ----------------------------------------------------------------------------
package dqe_pkg;

  // queue geometry
  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // port widths fixed by the interface
  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_COUNT      = 3'd6
  } op_t;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // per-cell load command
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_FRONT = 2'd1,
    CELL_FROM_BACK  = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_cmd_t;

endpackage

// ===== sv/dqe_cell.sv =====
// ----------------------------------------------------------------------------
// dqe_cell
// One storage cell of the queue chain; takes its word from the neighbor
// toward the front, the neighbor toward the back, or the pushed word.
// ----------------------------------------------------------------------------
module dqe_cell (
  input  logic              clk,
  input  dqe_pkg::cell_cmd_t cmd,
  input  dqe_pkg::word_t    front_word,
  input  dqe_pkg::word_t    back_word,
  input  dqe_pkg::word_t    push_word,
  output dqe_pkg::word_t    word
);

  // stored word, no reset needed
  always_ff @(posedge clk) begin
    unique case (cmd)
      dqe_pkg::CELL_FROM_FRONT: word <= front_word;
      dqe_pkg::CELL_FROM_BACK:  word <= back_word;
      dqe_pkg::CELL_LOAD:       word <= push_word;
      default:                  word <= word;
    endcase
  end

endmodule

// ===== sv/bounded_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded double-ended queue built as a row of shifting storage cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries op and value; output channel
//   (out_valid/out_ready) returns result_word, status and occupancy, one
//   result for every input transfer, in order.
//   Cell 0 always holds the front entry; cell occupancy-1 holds the back.
//   Push front shifts every cell one place toward the back, pop front shifts
//   one place toward the front, push back loads the cell at the fill count,
//   pop back only lowers the count. All of it happens in the accept cycle.
//   The result appears in the output register in the cycle after the
//   input transfer. One item per cycle while the receiver does not stall,
//   set by the cell update in the accept cycle and the one output register.
//   While the receiver stalls, the output register holds its result and
//   in_ready stays low; a new item is taken in the same cycle the held
//   result is transferred.
//   Reset clears the fill count and the output valid; cell contents are
//   left as they are and never read before being written.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_word,
  output logic [1:0]  status,
  output logic [4:0]  occupancy
);

  localparam int N = dqe_pkg::DEPTH;

  logic                 accept;
  dqe_pkg::cnt_t        count;
  dqe_pkg::cnt_t        count_next;
  dqe_pkg::word_t       push_word;
  dqe_pkg::word_t       cell_word [N];
  dqe_pkg::cell_cmd_t   cell_cmd  [N];
  dqe_pkg::word_t       back_word;
  dqe_pkg::word_t       word_next;
  logic [1:0]           status_next;
  logic                 is_full;
  logic                 is_empty;
  logic                 shift_back;
  logic                 shift_front;
  logic                 load_back;

  // handshake
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign push_word = dqe_pkg::word_t'(value);
  assign is_full   = (count == dqe_pkg::cnt_t'(N));
  assign is_empty  = (count == '0);

  // back entry select: the cell just below the fill count
  always_comb begin
    back_word = '0;
    for (int i = 0; i < N; i++) begin
      if (count == dqe_pkg::cnt_t'(i + 1)) back_word = back_word | cell_word[i];
    end
  end

  // operation decode
  always_comb begin
    count_next  = count;
    word_next   = '0;
    status_next = dqe_pkg::ST_OK;
    shift_back  = 1'b0;
    shift_front = 1'b0;
    load_back   = 1'b0;
    case (op)
      dqe_pkg::OP_PUSH_FRONT, dqe_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          status_next = dqe_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
          if (op == dqe_pkg::OP_PUSH_FRONT) shift_back = 1'b1;
          else                               load_back  = 1'b1;
        end
      end
      dqe_pkg::OP_POP_FRONT, dqe_pkg::OP_PEEK_FRONT: begin
        if (is_empty) begin
          status_next = dqe_pkg::ST_EMPTY;
        end else begin
          word_next = cell_word[0];
          if (op == dqe_pkg::OP_POP_FRONT) begin
            count_next  = count - 1'b1;
            shift_front = 1'b1;
          end
        end
      end
      dqe_pkg::OP_POP_BACK, dqe_pkg::OP_PEEK_BACK: begin
        if (is_empty) begin
          status_next = dqe_pkg::ST_EMPTY;
        end else begin
          word_next = back_word;
          if (op == dqe_pkg::OP_POP_BACK) count_next = count - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // per-cell commands
  always_comb begin
    for (int i = 0; i < N; i++) begin
      cell_cmd[i] = dqe_pkg::CELL_HOLD;
      if (accept) begin
        if (shift_back)       cell_cmd[i] = dqe_pkg::CELL_FROM_FRONT;
        else if (shift_front) cell_cmd[i] = dqe_pkg::CELL_FROM_BACK;
        else if (load_back && count == dqe_pkg::cnt_t'(i))
          cell_cmd[i] = dqe_pkg::CELL_LOAD;
      end
    end
  end

  // cell chain
  for (genvar g = 0; g < N; g++) begin : g_cell
    dqe_pkg::word_t front_nb;
    dqe_pkg::word_t back_nb;
    if (g == 0) begin : g_first
      assign front_nb = push_word;
    end else begin : g_mid_front
      assign front_nb = cell_word[g-1];
    end
    if (g == N - 1) begin : g_last
      assign back_nb = '0;
    end else begin : g_mid_back
      assign back_nb = cell_word[g+1];
    end
    dqe_cell u_cell (
      .clk        (clk),
      .cmd        (cell_cmd[g]),
      .front_word (front_nb),
      .back_word  (back_nb),
      .push_word  (push_word),
      .word       (cell_word[g])
    );
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_word <= 32'(word_next);
      status      <= status_next;
      occupancy   <= 5'(count_next);
    end
  end

endmodule

// ===== sv/dqe_checker.sv =====
// ----------------------------------------------------------------------------
// dqe_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module dqe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_word,
  input logic [1:0]  status,
  input logic [4:0]  occupancy
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_word)
      && $stable(status) && $stable(occupancy))
    else $error("stalled result changed");

  // refused push only when full
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dqe_pkg::ST_FULL |->
      occupancy == 5'(dqe_pkg::DEPTH) && result_word == '0)
    else $error("full status with room left");

  // refused pop or peek only when empty
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dqe_pkg::ST_EMPTY |-> occupancy == '0 && result_word == '0)
    else $error("empty status with entries stored");

  // every input transfer yields a result on the next cycle
  a_take_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer without a result");

endmodule

bind bounded_double_ended_queue dqe_checker u_dqe_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_word (result_word),
  .status      (status),
  .occupancy   (occupancy)
);

// ===== tb/bounded_double_ended_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_tb
// Drives push, pop, peek and count operations through the input channel,
// keeps its own copy of the deque contents to predict every result, and
// compares each result transfer field by field. Both channels idle and stall
// at random, including a long receiver hold-off and a full drain mid-run.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_tb;

  localparam int RANDOM_ITEMS = 1525;
  localparam int LONG_HOLD    = 64;
  localparam int SETTLE       = 6;
  localparam logic [dqe_pkg::OP_W-1:0] OP_SPARE = 3'd7;

  typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  typedef struct packed {
    logic [dqe_pkg::DATA_W-1:0]   word;
    logic [dqe_pkg::STATUS_W-1:0] status;
    logic [dqe_pkg::OCC_W-1:0]    occ;
  } deque_result_t;

  // deque shadow: predicts each result and matches it against the output
  class deque_scoreboard;
    dqe_pkg::word_t cells[dqe_pkg::DEPTH];
    int unsigned    head;
    int unsigned    fill;
    deque_result_t  awaited[$];
    int             errors;

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // apply one accepted operation to the shadow and queue its result
    function void note_transfer(logic [dqe_pkg::OP_W-1:0] code,
                                logic [dqe_pkg::DATA_W-1:0] data);
      deque_result_t r;
      r.word   = '0;
      r.status = dqe_pkg::ST_OK;
      case (code)
        dqe_pkg::OP_PUSH_FRONT, dqe_pkg::OP_PUSH_BACK: begin
          if (fill >= dqe_pkg::DEPTH) begin
            r.status = dqe_pkg::ST_FULL;
          end else if (code == dqe_pkg::OP_PUSH_FRONT) begin
            head = (head + dqe_pkg::DEPTH - 1) % dqe_pkg::DEPTH;
            cells[head] = data[dqe_pkg::WORD_BITS-1:0];
            fill++;
          end else begin
            cells[(head + fill) % dqe_pkg::DEPTH] = data[dqe_pkg::WORD_BITS-1:0];
            fill++;
          end
        end
        dqe_pkg::OP_POP_FRONT, dqe_pkg::OP_PEEK_FRONT: begin
          if (fill == 0) begin
            r.status = dqe_pkg::ST_EMPTY;
          end else begin
            r.word = dqe_pkg::DATA_W'(cells[head]);
            if (code == dqe_pkg::OP_POP_FRONT) begin
              head = (head + 1) % dqe_pkg::DEPTH;
              fill--;
            end
          end
        end
        dqe_pkg::OP_POP_BACK, dqe_pkg::OP_PEEK_BACK: begin
          if (fill == 0) begin
            r.status = dqe_pkg::ST_EMPTY;
          end else begin
            r.word = dqe_pkg::DATA_W'(cells[(head + fill - 1) % dqe_pkg::DEPTH]);
            if (code == dqe_pkg::OP_POP_BACK) fill--;
          end
        end
        default: begin
          // count and the spare code leave everything as it is
        end
      endcase
      r.occ = dqe_pkg::OCC_W'(fill);
      awaited.push_back(r);
    endfunction

    // compare one result transfer against the oldest prediction
    function void check_result(logic [dqe_pkg::DATA_W-1:0] word,
                               logic [dqe_pkg::STATUS_W-1:0] st,
                               logic [dqe_pkg::OCC_W-1:0] occ);
      deque_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing awaited: word %h status %0d occupancy %0d",
                 $time, word, st, occ);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (word !== e.word) begin
        $display("%0t: result_word expected %h actual %h", $time, e.word, word);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (occ !== e.occ) begin
        $display("%0t: occupancy expected %0d actual %0d", $time, e.occ, occ);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic [dqe_pkg::OP_W-1:0]   op;
  logic [dqe_pkg::DATA_W-1:0] value;
  logic                       out_valid;
  logic                       out_ready;
  logic [dqe_pkg::DATA_W-1:0] result_word;
  logic [1:0]                 status;
  logic [4:0]                 occupancy;
  int                         hold_asked;
  int                         hold_given;

  deque_scoreboard sb = new();

  bounded_double_ended_queue uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_word(result_word),
    .status     (status),
    .occupancy  (occupancy)
  );

  // clock generation
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(result_word, status, occupancy);
  end

  // present one operation and hold it until the transfer
  task automatic offer_op(input logic [dqe_pkg::OP_W-1:0] code,
                          input logic [dqe_pkg::DATA_W-1:0] data);
    @(negedge clk);
    op       = code;
    value    = data;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(code, data);
  endtask

  // drop valid for a number of cycles
  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // stop sending until every predicted result has come back
  task automatic await_drain();
    idle_sender(1);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [dqe_pkg::OP_W-1:0] choose_op(lean_t lean);
    int r;
    int push_pct;
    int pop_pct;
    r        = $urandom_range(0, 99);
    push_pct = (lean == LEAN_FILL) ? 60 : (lean == LEAN_DRAIN) ? 15 : 35;
    pop_pct  = (lean == LEAN_FILL) ? 20 : (lean == LEAN_DRAIN) ? 65 : 35;
    if (r == 0) return OP_SPARE;
    if (r <= push_pct)
      return $urandom_range(0, 1) ? dqe_pkg::OP_PUSH_FRONT : dqe_pkg::OP_PUSH_BACK;
    if (r <= push_pct + pop_pct)
      return $urandom_range(0, 1) ? dqe_pkg::OP_POP_FRONT : dqe_pkg::OP_POP_BACK;
    case ($urandom_range(0, 2))
      0:       return dqe_pkg::OP_PEEK_FRONT;
      1:       return dqe_pkg::OP_PEEK_BACK;
      default: return dqe_pkg::OP_COUNT;
    endcase
  endfunction

  function automatic logic [dqe_pkg::DATA_W-1:0] choose_word();
    logic [dqe_pkg::DATA_W-1:0] one_hot;
    one_hot = dqe_pkg::DATA_W'(1) << $urandom_range(0, dqe_pkg::DATA_W - 1);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  // receiver: ready pattern changes from stretch to stretch
  initial begin : receiver
    rx_mode_t mode;
    int       span;
    int       period;
    int       beat;
    hold_given = 0;
    @(negedge rst);
    forever begin
      mode   = rx_mode_t'($urandom_range(0, 3));
      span   = $urandom_range(20, 200);
      period = $urandom_range(2, 7);
      beat   = 0;
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        if (hold_given < hold_asked) begin
          // long hold-off so the input side backs up
          out_ready = 1'b0;
          repeat (LONG_HOLD - 1) @(negedge clk);
          hold_given++;
        end else begin
          case (mode)
            RX_OPEN:   out_ready = 1'b1;
            RX_COIN:   out_ready = $urandom_range(0, 1);
            RX_SPARSE: out_ready = ($urandom_range(0, 4) != 0);
            default:   out_ready = (beat % period) < (period - 1);
          endcase
          beat++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    lean_t lean;
    int    burst;
    int    sent;
    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = dqe_pkg::OP_COUNT;
    value      = '0;
    out_ready  = 1'b0;
    hold_asked = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty queue: every read is refused, spare code acts as count
    offer_op(dqe_pkg::OP_POP_FRONT, 32'h0000_0000);
    offer_op(dqe_pkg::OP_POP_BACK, 32'hFFFF_FFFF);
    offer_op(dqe_pkg::OP_PEEK_FRONT, 32'h0000_0000);
    offer_op(dqe_pkg::OP_PEEK_BACK, 32'hFFFF_FFFF);
    offer_op(OP_SPARE, 32'hFFFF_FFFF);
    // single element: peek keeps it, pop of the last one empties
    offer_op(dqe_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    offer_op(dqe_pkg::OP_PEEK_FRONT, 32'h0000_0000);
    offer_op(dqe_pkg::OP_PEEK_BACK, 32'h0000_0000);
    offer_op(dqe_pkg::OP_POP_BACK, 32'h0000_0000);
    offer_op(dqe_pkg::OP_COUNT, 32'h1234_5678);
    // fill from both ends, wrapping the ring, then refuse pushes when full
    for (int i = 0; i < dqe_pkg::DEPTH; i++) begin
      offer_op((i % 3 == 0) ? dqe_pkg::OP_PUSH_BACK : dqe_pkg::OP_PUSH_FRONT,
               (i == 0) ? 32'h0000_0000 : (i == 1) ? 32'hFFFF_FFFF : $urandom);
    end
    offer_op(dqe_pkg::OP_PUSH_FRONT, 32'hA5A5_A5A5);
    offer_op(dqe_pkg::OP_PUSH_BACK, 32'h5A5A_5A5A);
    offer_op(dqe_pkg::OP_COUNT, 32'h0000_0000);
    await_drain();

    // random bursts, leaning toward filling or draining
    sent = 0;
    lean = LEAN_FILL;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 30);
      if ($urandom_range(0, 2) == 0) lean = lean_t'($urandom_range(0, 2));
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        offer_op(choose_op(lean), choose_word());
        sent++;
        if (sent == 400 || sent == 1100) hold_asked++;
        if (sent == 750) await_drain();
      end
      // some stretches run back to back with no gaps
      if ((sent / 250) % 3 != 0) idle_sender($urandom_range(0, 12));
    end
    idle_sender(1);

    for (int t = 0; t < 5000 && sb.pending() != 0; t++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== bounded_double_ended_queue.f =====
sv/dqe_pkg.sv
sv/dqe_cell.sv
sv/bounded_double_ended_queue.sv
sv/dqe_checker.sv
tb/bounded_double_ended_queue_tb.sv
